@@ src/vnm_pkg.sv @@
// Shared constants, types and helpers for the voxel 26-neighbor mask block.
// No dependencies; every other file imports it.
package vnm_pkg;

    localparam int MAX_LINE   = 256;
    localparam int MAX_LINES  = 256;
    localparam int MAX_PLANES = 4096;

    localparam int X_W         = $clog2(MAX_LINE);
    localparam int Y_W         = $clog2(MAX_LINES);
    localparam int Z_W         = $clog2(MAX_PLANES);
    localparam int P_W         = X_W + Y_W;
    localparam int PLANE_DEPTH = 1 << P_W;
    localparam int LAG_W       = $clog2(MAX_LINE * MAX_LINES + MAX_LINE + 2);

    localparam int VAL_W    = 16;
    localparam int THR_W    = 16;
    localparam int SXY_W    = 9;
    localparam int SZ_W     = 13;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int POS_XY_W = 8;
    localparam int POS_Z_W  = 12;
    localparam int MASK_W   = 26;
    localparam int WIN_W    = 27;
    localparam int CENTRE   = 13;

    localparam int THR_RESET  = 6554;
    localparam int SIZE_RESET = 256;

    localparam int SX_RESET_EFF = (SIZE_RESET > MAX_LINE)   ? MAX_LINE   : SIZE_RESET;
    localparam int SY_RESET_EFF = (SIZE_RESET > MAX_LINES)  ? MAX_LINES  : SIZE_RESET;
    localparam int SZ_RESET_EFF = (SIZE_RESET > MAX_PLANES) ? MAX_PLANES : SIZE_RESET;

    localparam logic [X_W-1:0]   XL_RESET  = X_W'(SX_RESET_EFF - 1);
    localparam logic [Y_W-1:0]   YL_RESET  = Y_W'(SY_RESET_EFF - 1);
    localparam logic [Z_W-1:0]   ZL_RESET  = Z_W'(SZ_RESET_EFF - 1);
    localparam logic [LAG_W-1:0] LAG_RESET =
        LAG_W'(SX_RESET_EFF * SY_RESET_EFF + SX_RESET_EFF + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SIZE_X    = 2'd1,
        REG_SIZE_Y    = 2'd2,
        REG_SIZE_Z    = 2'd3
    } vnm_cfg_t;

    // One stream advance, shared by every delay cell.
    typedef struct packed {
        logic           push;
        logic           din;
        logic [X_W-1:0] wr_x;
        logic [X_W-1:0] rd_x;
        logic [P_W-1:0] wr_p;
        logic [P_W-1:0] rd_p;
    } vnm_adv_t;

    // Last index of a dimension: zero acts as one, oversize saturates.
    function automatic logic [Z_W-1:0] dim_last(input logic [SZ_W-1:0] raw, input int max_dim);
        if (raw == '0)
            return '0;
        if (int'(raw) > max_dim)
            return Z_W'(max_dim - 1);
        return Z_W'(int'(raw) - 1);
    endfunction

    // ok*[0]: step -1 inside, ok*[1]: step 0, ok*[2]: step +1 inside.
    function automatic logic [MASK_W-1:0] nbr_mask(
        input logic [WIN_W-1:0] win,
        input logic [2:0]       okx,
        input logic [2:0]       oky,
        input logic [2:0]       okz
    );
        logic [WIN_W-1:0] hit;
        for (int zi = 0; zi < 3; zi++)
        begin
            for (int yi = 0; yi < 3; yi++)
            begin
                for (int xi = 0; xi < 3; xi++)
                begin
                    hit[zi * 9 + yi * 3 + xi] =
                        win[zi * 9 + yi * 3 + xi] & okz[zi] & oky[yi] & okx[xi];
                end
            end
        end
        return {hit[WIN_W-1:CENTRE+1], hit[CENTRE-1:0]};
    endfunction

endpackage

@@ src/vnm_row_cell.sv @@
// Row cell: three-voxel tap register plus a one-line delay memory.
// Depends on vnm_pkg.
module vnm_row_cell
    import vnm_pkg::*;
(
    input  logic       clk,
    input  vnm_adv_t   adv,
    input  logic       bit_in,
    output logic [2:0] taps,
    output logic       line_out
);

    logic       line_mem [MAX_LINE];
    logic [2:0] taps_reg;
    logic       line_reg;

    // Read the slot of the next position so the delayed bit lines up one advance later.
    always_ff @(posedge clk)
    begin
        if (adv.push)
        begin
            taps_reg <= {taps_reg[1:0], bit_in};
            if (adv.rd_x == adv.wr_x)
                line_reg <= bit_in;
            else
                line_reg <= line_mem[adv.rd_x];
            line_mem[adv.wr_x] <= bit_in;
        end
    end

    assign taps     = taps_reg;
    assign line_out = line_reg;

endmodule

@@ src/vnm_plane_delay.sv @@
// Plane delay: one-plane and two-plane delayed occupancy streams from one memory.
// Depends on vnm_pkg.
module vnm_plane_delay
    import vnm_pkg::*;
(
    input  logic       clk,
    input  vnm_adv_t   adv,
    output logic [1:0] lvl_out
);

    logic [1:0] plane_mem [PLANE_DEPTH];
    logic [1:0] plane_reg;
    logic [1:0] wr_word;

    // bit 0: newest stream, bit 1: stream already one plane old
    assign wr_word = {plane_reg[0], adv.din};

    always_ff @(posedge clk)
    begin
        if (adv.push)
        begin
            if (adv.rd_p == adv.wr_p)
                plane_reg <= wr_word;
            else
                plane_reg <= plane_mem[adv.rd_p];
            plane_mem[adv.wr_p] <= wr_word;
        end
    end

    assign lvl_out = plane_reg;

endmodule

@@ src/vnm_window.sv @@
// 3x3x3 occupancy window: the input and the plane delay feeding three chains of three row cells.
// Depends on vnm_pkg, vnm_plane_delay and vnm_row_cell.
module vnm_window
    import vnm_pkg::*;
(
    input  logic             clk,
    input  vnm_adv_t         adv,
    output logic [WIN_W-1:0] win
);

    logic [1:0] plane_out;
    logic [2:0] lvl_in;
    logic [2:0] row_taps  [3][3];
    logic       line_link [3][3];

    vnm_plane_delay u_plane (
        .clk     (clk),
        .adv     (adv),
        .lvl_out (plane_out)
    );

    assign lvl_in = {plane_out, adv.din};

    for (genvar lv = 0; lv < 3; lv++)
    begin : g_lvl
        for (genvar rw = 0; rw < 3; rw++)
        begin : g_row
            if (rw == 0)
            begin : g_head
                vnm_row_cell u_cell (
                    .clk      (clk),
                    .adv      (adv),
                    .bit_in   (lvl_in[lv]),
                    .taps     (row_taps[lv][rw]),
                    .line_out (line_link[lv][rw])
                );
            end
            else
            begin : g_tail
                vnm_row_cell u_cell (
                    .clk      (clk),
                    .adv      (adv),
                    .bit_in   (line_link[lv][rw-1]),
                    .taps     (row_taps[lv][rw]),
                    .line_out (line_link[lv][rw])
                );
            end
        end
    end

    // Level, row and tap count back from the newest voxel.
    for (genvar zi = 0; zi < 3; zi++)
    begin : g_wz
        for (genvar yi = 0; yi < 3; yi++)
        begin : g_wy
            for (genvar xi = 0; xi < 3; xi++)
            begin : g_wx
                assign win[zi * 9 + yi * 3 + xi] = row_taps[2-zi][2-yi][2-xi];
            end
        end
    end

endmodule

@@ src/voxel_neighbour_mask_26_core.sv @@
// Top level of the voxel 26-neighbor occupancy mask block.
// Depends on vnm_pkg and vnm_window.
//
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always ready.
//     Index 0 threshold, 1..3 size x/y/z. A size write restarts the volume.
//   in channel: one request per voxel in raster order (x fastest), or a pad
//     request; after the volume is complete every request acts as a pad.
//   out channel: one request per voxel, delayed by one plane, one line and one
//     voxel of the input stream, plus one register stage.
// Throughput: one request per cycle on both sides while neither side stalls. The result
//   for a voxel is registered in the window stage, then the output register, after the
//   input request one plane + line + voxel later. Volumes with no more voxels than
//   that lag: after the final voxel in_ready drops while the window is pushed on with
//   empty voxels until the first result; pads then flow one per cycle again when unstalled.
// Reset: counters and handshakes clear; sizes return to 256, threshold to 6554.
//   The line and plane memories are not cleared: unwritten slots only ever
//   land on neighbors outside the volume, which are masked.
// Receiver stall: the output register holds, the window freezes and in_ready
//   drops in the same cycle.
module voxel_neighbour_mask_26_core
    import vnm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VAL_W-1:0]     voxel_value,
    input  logic                 is_pad,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_XY_W-1:0]  pos_x,
    output logic [POS_XY_W-1:0]  pos_y,
    output logic [POS_Z_W-1:0]   pos_z,
    output logic                 occupied,
    output logic [MASK_W-1:0]    neighbour_mask,
    output logic                 last_voxel
);

    // configuration
    logic [THR_W-1:0] thr_reg, thr_next;
    logic [X_W-1:0]   xl_reg, xl_next;
    logic [Y_W-1:0]   yl_reg, yl_next;
    logic [Z_W-1:0]   zl_reg, zl_next;
    logic [LAG_W-1:0] lag_reg, lag_next;
    logic [X_W:0]     sx_len;
    logic [Y_W:0]     sy_len;
    logic [P_W+1:0]   plane_prod;
    logic             size_wr;

    // input stream position
    logic [X_W-1:0]   x_in_reg, x_in_next, x_step;
    logic [Y_W-1:0]   y_in_reg, y_in_next, y_step;
    logic [Z_W-1:0]   z_in_reg, z_in_next, z_step;
    logic             x_wrap, y_wrap;
    logic             done_reg, done_next;
    logic             owe_reg, owe_next;
    logic [LAG_W-1:0] warm_reg, warm_next;

    // centre position
    logic [X_W-1:0]   cx_reg, cx_next;
    logic [Y_W-1:0]   cy_reg, cy_next;
    logic [Z_W-1:0]   cz_reg, cz_next;
    logic             cx_wrap, cy_wrap, centre_last;

    // handshake and stream advance
    logic             go, in_acc, self_push, push, real_vox, din, emit, last_in, vol_end;
    vnm_adv_t         adv;
    logic [WIN_W-1:0] win;

    // window stage
    logic             win_valid_reg;
    logic [X_W-1:0]   win_x_reg;
    logic [Y_W-1:0]   win_y_reg;
    logic [Z_W-1:0]   win_z_reg;
    logic             win_last_reg;

    // output stage
    logic              out_valid_reg;
    logic [X_W-1:0]    out_x_reg;
    logic [Y_W-1:0]    out_y_reg;
    logic [Z_W-1:0]    out_z_reg;
    logic              out_occ_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_last_reg;
    logic [2:0]        okx, oky, okz;

    assign cfg_ready = 1'b1;
    assign size_wr   = cfg_valid && (cfg_index != REG_THRESHOLD);

    always_comb
    begin
        thr_next = thr_reg;
        xl_next  = xl_reg;
        yl_next  = yl_reg;
        zl_next  = zl_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_next = cfg_data[THR_W-1:0];
                REG_SIZE_X:    xl_next  = X_W'(dim_last(SZ_W'(cfg_data[SXY_W-1:0]), MAX_LINE));
                REG_SIZE_Y:    yl_next  = Y_W'(dim_last(SZ_W'(cfg_data[SXY_W-1:0]), MAX_LINES));
                REG_SIZE_Z:    zl_next  = dim_last(cfg_data[SZ_W-1:0], MAX_PLANES);
                default:       thr_next = thr_reg;
            endcase
        end
    end

    // lag = plane + line + 1
    assign sx_len     = (X_W+1)'(xl_reg) + (X_W+1)'(1);
    assign sy_len     = (Y_W+1)'(yl_reg) + (Y_W+1)'(1);
    assign plane_prod = (P_W+2)'(sx_len) * (P_W+2)'(sy_len);
    assign lag_next   = LAG_W'(plane_prod) + LAG_W'(sx_len) + LAG_W'(1);

    // handshake
    assign go        = !out_valid_reg || out_ready;
    assign in_ready  = go && !owe_reg;
    assign in_acc    = in_valid && in_ready;
    assign self_push = go && owe_reg;
    assign push      = in_acc || self_push;
    assign real_vox  = in_acc && !done_reg;
    assign din       = real_vox && !is_pad && (voxel_value > thr_reg);
    assign emit      = push && (warm_reg == lag_reg);

    assign x_wrap  = (x_in_reg == xl_reg);
    assign y_wrap  = (y_in_reg == yl_reg);
    assign x_step  = x_wrap ? '0 : x_in_reg + X_W'(1);
    assign y_step  = x_wrap ? (y_wrap ? '0 : y_in_reg + Y_W'(1)) : y_in_reg;
    assign z_step  = (x_wrap && y_wrap) ? z_in_reg + Z_W'(1) : z_in_reg;
    assign last_in = real_vox && x_wrap && y_wrap && (z_in_reg == zl_reg);

    assign cx_wrap     = (cx_reg == xl_reg);
    assign cy_wrap     = (cy_reg == yl_reg);
    assign centre_last = cx_wrap && cy_wrap && (cz_reg == zl_reg);
    assign vol_end     = emit && centre_last;

    always_comb
    begin
        adv.push = push;
        adv.din  = din;
        adv.wr_x = x_in_reg;
        adv.rd_x = x_step;
        adv.wr_p = {y_in_reg, x_in_reg};
        adv.rd_p = {y_step, x_step};
    end

    always_comb
    begin
        x_in_next = x_in_reg;
        y_in_next = y_in_reg;
        z_in_next = z_in_reg;
        done_next = done_reg;
        owe_next  = owe_reg;
        warm_next = warm_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        cz_next   = cz_reg;
        if (push)
        begin
            x_in_next = x_step;
            y_in_next = y_step;
            z_in_next = z_step;
            if (warm_reg != lag_reg)
                warm_next = warm_reg + LAG_W'(1);
            if (last_in)
                done_next = 1'b1;
            // final voxel came before the window filled: push empties until it has
            if (last_in && !emit)
                owe_next = 1'b1;
            if (self_push && emit)
                owe_next = 1'b0;
            if (emit)
            begin
                cx_next = cx_wrap ? '0 : cx_reg + X_W'(1);
                cy_next = cx_wrap ? (cy_wrap ? '0 : cy_reg + Y_W'(1)) : cy_reg;
                cz_next = (cx_wrap && cy_wrap) ? cz_reg + Z_W'(1) : cz_reg;
            end
        end
        if (vol_end || size_wr)
        begin
            x_in_next = '0;
            y_in_next = '0;
            z_in_next = '0;
            done_next = 1'b0;
            owe_next  = 1'b0;
            warm_next = '0;
            cx_next   = '0;
            cy_next   = '0;
            cz_next   = '0;
        end
    end

    vnm_window u_window (
        .clk (clk),
        .adv (adv),
        .win (win)
    );

    assign okx = {win_x_reg != xl_reg, 1'b1, win_x_reg != '0};
    assign oky = {win_y_reg != yl_reg, 1'b1, win_y_reg != '0};
    assign okz = {win_z_reg != zl_reg, 1'b1, win_z_reg != '0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_W'(THR_RESET);
            xl_reg        <= XL_RESET;
            yl_reg        <= YL_RESET;
            zl_reg        <= ZL_RESET;
            lag_reg       <= LAG_RESET;
            x_in_reg      <= '0;
            y_in_reg      <= '0;
            z_in_reg      <= '0;
            done_reg      <= 1'b0;
            owe_reg       <= 1'b0;
            warm_reg      <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            win_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg  <= thr_next;
            xl_reg   <= xl_next;
            yl_reg   <= yl_next;
            zl_reg   <= zl_next;
            lag_reg  <= lag_next;
            x_in_reg <= x_in_next;
            y_in_reg <= y_in_next;
            z_in_reg <= z_in_next;
            done_reg <= done_next;
            owe_reg  <= owe_next;
            warm_reg <= warm_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            cz_reg   <= cz_next;
            if (push)
                win_valid_reg <= emit;
            else if (go)
                win_valid_reg <= 1'b0;
            if (go)
                out_valid_reg <= win_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            win_x_reg    <= cx_reg;
            win_y_reg    <= cy_reg;
            win_z_reg    <= cz_reg;
            win_last_reg <= centre_last;
        end
        if (go && win_valid_reg)
        begin
            out_x_reg    <= win_x_reg;
            out_y_reg    <= win_y_reg;
            out_z_reg    <= win_z_reg;
            out_occ_reg  <= win[CENTRE];
            out_mask_reg <= nbr_mask(win, okx, oky, okz);
            out_last_reg <= win_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pos_x          = POS_XY_W'(out_x_reg);
    assign pos_y          = POS_XY_W'(out_y_reg);
    assign pos_z          = POS_Z_W'(out_z_reg);
    assign occupied       = out_occ_reg;
    assign neighbour_mask = out_mask_reg;
    assign last_voxel     = out_last_reg;

endmodule

@@ tb/tb_voxel_neighbour_mask_26_core.sv @@
// Self-checking testbench for voxel_neighbour_mask_26_core: streams voxel volumes
// through the block and checks every neighbor-mask result against a local predictor.
// Depends on vnm_pkg and the RTL of voxel_neighbour_mask_26_core.
`timescale 1ns / 100ps

module tb_voxel_neighbour_mask_26_core;
    import vnm_pkg::*;

    localparam int RING_DEPTH = 2 * MAX_LINE * MAX_LINES + 2 * MAX_LINE + 3;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             pad;
    } voxel_req_t;

    typedef struct packed {
        logic [POS_XY_W-1:0] px;
        logic [POS_XY_W-1:0] py;
        logic [POS_Z_W-1:0]  pz;
        logic                occ;
        logic [MASK_W-1:0]   mask;
        logic                last;
    } nbr_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [VAL_W-1:0]     voxel_value = '0;
    logic                 is_pad = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [POS_XY_W-1:0]  pos_x;
    logic [POS_XY_W-1:0]  pos_y;
    logic [POS_Z_W-1:0]   pos_z;
    logic                 occupied;
    logic [MASK_W-1:0]    neighbour_mask;
    logic                 last_voxel;

    // predictor state and register copies
    logic [THR_W-1:0] thr_cfg = THR_RESET;
    logic [SXY_W-1:0] sx_cfg = SIZE_RESET;
    logic [SXY_W-1:0] sy_cfg = SIZE_RESET;
    logic [SZ_W-1:0]  sz_cfg = SIZE_RESET;
    bit               occ_ring [RING_DEPTH];
    longint           in_pos = 0;
    longint           ctr_pos = 0;

    voxel_req_t  voxel_q[$];
    nbr_result_t mask_expect_q[$];
    voxel_req_t  next_req;
    nbr_result_t want;
    nbr_result_t got;

    int items_queued = 0;
    int items_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int hold_left = 0;
    int stall_at = 32'h7fff_ffff;
    bit stall_done = 1'b0;
    bit steady = 1'b0;
    logic in_taken = 1'b0;

    voxel_neighbour_mask_26_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .voxel_value    (voxel_value),
        .is_pad         (is_pad),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .occupied       (occupied),
        .neighbour_mask (neighbour_mask),
        .last_voxel     (last_voxel)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb_voxel_neighbour_mask_26_core failed");
        $finish;
    end

    function automatic longint eff_size(input longint raw, input longint lim);
        if (raw == 0)
            return 1;
        if (raw > lim)
            return lim;
        return raw;
    endfunction

    function automatic longint volume_total();
        return eff_size(sx_cfg, MAX_LINE) * eff_size(sy_cfg, MAX_LINES) *
               eff_size(sz_cfg, MAX_PLANES);
    endfunction

    function automatic longint volume_lag();
        longint sx;
        sx = eff_size(sx_cfg, MAX_LINE);
        return sx * eff_size(sy_cfg, MAX_LINES) + sx + 1;
    endfunction

    // flush requests needed after the last voxel to drain every result
    function automatic int flush_items();
        longint total;
        longint early;
        total = volume_total();
        early = total - 1 - volume_lag();
        if (early < 0)
            early = 0;
        return int'(total - early - 1);
    endfunction

    task automatic predict_neighbourhood(input logic [VAL_W-1:0] value, input logic pad);
        longint      sx;
        longint      sy;
        longint      sz;
        longint      plane;
        longint      total;
        longint      cx;
        longint      cy;
        longint      cz;
        longint      nx;
        longint      ny;
        longint      nz;
        int          bitn;
        nbr_result_t r;
        sx = eff_size(sx_cfg, MAX_LINE);
        sy = eff_size(sy_cfg, MAX_LINES);
        sz = eff_size(sz_cfg, MAX_PLANES);
        plane = sx * sy;
        total = plane * sz;
        if (in_pos < total)
        begin
            occ_ring[in_pos % RING_DEPTH] = !pad && (value > thr_cfg);
            in_pos++;
        end
        if (ctr_pos < total && (ctr_pos + volume_lag() < in_pos || in_pos >= total))
        begin
            cx = ctr_pos % sx;
            cy = (ctr_pos / sx) % sy;
            cz = ctr_pos / plane;
            r = '0;
            bitn = 0;
            for (int dz = -1; dz <= 1; dz++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        if (dx == 0 && dy == 0 && dz == 0)
                            continue;
                        nx = cx + dx;
                        ny = cy + dy;
                        nz = cz + dz;
                        if (nx >= 0 && nx < sx && ny >= 0 && ny < sy && nz >= 0 && nz < sz)
                            r.mask[bitn] = occ_ring[(nx + ny * sx + nz * plane) % RING_DEPTH];
                        bitn++;
                    end
            r.px = POS_XY_W'(cx);
            r.py = POS_XY_W'(cy);
            r.pz = POS_Z_W'(cz);
            r.occ = occ_ring[ctr_pos % RING_DEPTH];
            r.last = (ctr_pos == total - 1);
            mask_expect_q.push_back(r);
            if (r.last)
            begin
                in_pos = 0;
                ctr_pos = 0;
            end
            else
                ctr_pos++;
        end
    endtask

    function automatic bit field_ok(input string name, input longint exp_v, input longint act_v);
        if (exp_v == act_v)
            return 1'b1;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
        return 1'b0;
    endfunction

    // input side: accept, predict
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                predict_neighbourhood(voxel_value, is_pad);
                items_taken++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (voxel_q.size() != 0 && (steady || $urandom_range(99) >= 38))
            begin
                next_req = voxel_q.pop_front();
                in_valid <= 1'b1;
                voxel_value <= next_req.value;
                is_pad <= next_req.pad;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side
    always @(negedge clk)
    begin
        if (!stall_done && results_seen >= stall_at)
        begin
            hold_left = 300;
            stall_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= 38);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            got = '{pos_x, pos_y, pos_z, occupied, neighbour_mask, last_voxel};
            if (mask_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                errors++;
            end
            else
            begin
                want = mask_expect_q.pop_front();
                if (!(field_ok("pos_x", want.px, got.px) &
                      field_ok("pos_y", want.py, got.py) &
                      field_ok("pos_z", want.pz, got.pz) &
                      field_ok("occupied", want.occ, got.occ) &
                      field_ok("neighbour_mask", want.mask, got.mask) &
                      field_ok("last_voxel", want.last, got.last)))
                    errors++;
            end
        end
    end

    task automatic write_reg(input vnm_cfg_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_THRESHOLD: thr_cfg = data[THR_W-1:0];
            REG_SIZE_X:    sx_cfg = data[SXY_W-1:0];
            REG_SIZE_Y:    sy_cfg = data[SXY_W-1:0];
            REG_SIZE_Z:    sz_cfg = data[SZ_W-1:0];
        endcase
        if (idx != REG_THRESHOLD)
        begin
            in_pos = 0;
            ctr_pos = 0;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_volume(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
                              input logic [CFG_W-1:0] sz);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
    endtask

    task automatic send_voxel(input logic [VAL_W-1:0] value, input logic pad);
        voxel_q.push_back('{value, pad});
        items_queued++;
    endtask

    task automatic send_random_voxels(input int n);
        for (int i = 0; i < n; i++)
            send_voxel(VAL_W'($urandom_range(65535)), $urandom_range(99) < 8);
    endtask

    task automatic send_flush(input int n);
        for (int i = 0; i < n; i++)
            send_voxel(VAL_W'($urandom_range(65535)), 1'($urandom_range(1)));
    endtask

    // wait for every request taken and every result back, then let the block settle
    task automatic drain();
        while (items_taken != items_queued || mask_expect_q.size() != 0)
            @(negedge clk);
        repeat (int'(volume_lag()) + 16) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int     random_items;
        int     n;
        longint total;
        random_items = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // threshold edges, pad inside volume, voxel after volume end
        write_reg(REG_THRESHOLD, 16'd100);
        set_volume(2, 2, 2);
        send_voxel(16'd0, 1'b0);
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'd100, 1'b0);
        send_voxel(16'd101, 1'b0);
        send_voxel(16'hFFFF, 1'b1);
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'd101, 1'b0);
        send_voxel(16'd0, 1'b0);
        send_voxel(16'hFFFF, 1'b0);
        send_flush(flush_items() - 1);
        drain();

        // zero sizes act as one, threshold at top
        write_reg(REG_THRESHOLD, 16'hFFFF);
        set_volume(0, 0, 0);
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'd0, 1'b0);
        send_voxel(16'hFFFF, 1'b1);
        drain();

        // volume smaller than the lag, threshold at zero
        write_reg(REG_THRESHOLD, 16'd0);
        set_volume(2, 2, 1);
        send_voxel(16'd1, 1'b0);
        send_voxel(16'd0, 1'b0);
        send_voxel(16'd1, 1'b0);
        send_voxel(16'd1, 1'b0);
        send_flush(flush_items());
        drain();

        // widest line, no idling on either side
        write_reg(REG_THRESHOLD, CFG_W'($urandom_range(65535)));
        set_volume(256, 1, 1);
        steady = 1'b1;
        send_random_voxels(int'(volume_total()));
        send_flush(flush_items());
        drain();
        steady = 1'b0;

        // oversize line count, long receiver stall
        write_reg(REG_THRESHOLD, CFG_W'($urandom_range(65535)));
        set_volume(1, 300, 1);
        stall_at = results_seen + 40;
        send_random_voxels(int'(volume_total()));
        send_flush(flush_items());
        drain();

        // oversize plane count, aborted by the next size write
        write_reg(REG_THRESHOLD, CFG_W'($urandom_range(65535)));
        set_volume(1, 1, 16'hFFFF);
        send_random_voxels(60);
        drain();

        while (random_items < 400)
        begin
            if ($urandom_range(3) != 0)
                write_reg(REG_THRESHOLD, CFG_W'($urandom_range(65535)));
            set_volume(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6),
                       ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6),
                       ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5));
            total = volume_total();
            if ($urandom_range(99) < 15)
            begin
                n = $urandom_range(1, int'(total));
                send_random_voxels(n);
                random_items += n;
            end
            else
            begin
                n = flush_items();
                send_random_voxels(int'(total));
                send_flush(n);
                random_items += int'(total) + n;
            end
            drain();
        end

        if (errors == 0 && mask_expect_q.size() == 0)
            $display("tb_voxel_neighbour_mask_26_core passed");
        else
            $display("tb_voxel_neighbour_mask_26_core failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/vnm_pkg.sv
src/vnm_row_cell.sv
src/vnm_plane_delay.sv
src/vnm_window.sv
src/voxel_neighbour_mask_26_core.sv
tb/tb_voxel_neighbour_mask_26_core.sv
